// File: src/dpwm_pkg.sv
// Shared types and constants for the two-channel dimmer PWM.
package dpwm_pkg;

	// Width of the period register and of every tick counter.
	localparam int unsigned PERIOD_W = 10;

	// Period after reset, in ticks.
	localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(10);

	// Item opcodes.
	typedef enum logic {
		OP_TICK   = 1'b0,
		OP_UPDATE = 1'b1
	} dpwm_op_t;

	// Per-channel control for one processed item.
	typedef struct packed {
		logic tick;
		logic update;
		logic on_mode;
		logic dim_mode;
	} dpwm_ctrl_t;

endpackage

// File: src/dpwm_scale.sv
// Duty scaling: floor(period * duty / (2^SAMPLE_BITS - 1)) without a divider.
module dpwm_scale #(
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  logic [dpwm_pkg::PERIOD_W-1:0] period,
	input  logic [SAMPLE_BITS-1:0]        duty,
	output logic [dpwm_pkg::PERIOD_W-1:0] on_ticks
);

	localparam int unsigned PW = dpwm_pkg::PERIOD_W + SAMPLE_BITS;
	localparam int unsigned YW =
		((SAMPLE_BITS > dpwm_pkg::PERIOD_W) ? SAMPLE_BITS : dpwm_pkg::PERIOD_W) + 1;
	localparam logic [SAMPLE_BITS-1:0] FULL = '1;

	logic [PW-1:0] prod;
	logic [YW-1:0] q1;
	logic [YW-1:0] y1;
	logic [YW-1:0] q2;
	logic [YW-1:0] y2;
	logic          corr;
	logic [YW-1:0] quot;

	// Division by 2^S - 1: x = q*2^S + r = q*(2^S - 1) + (q + r), so fold the
	// high part back onto the low part twice; what is left is below twice the
	// divisor and needs a single compare.
	always_comb begin
		prod = PW'(period) * PW'(duty);
		q1   = YW'(prod >> SAMPLE_BITS);
		y1   = q1 + YW'(prod[SAMPLE_BITS-1:0]);
		q2   = y1 >> SAMPLE_BITS;
		y2   = q2 + YW'(y1[SAMPLE_BITS-1:0]);
		corr = (y2 >= YW'(FULL));
		quot = q1 + q2 + YW'(corr);
	end

	// The quotient never exceeds the period since the duty is at most full scale.
	assign on_ticks = quot[dpwm_pkg::PERIOD_W-1:0];

endmodule

// File: src/dpwm_channel.sv
// One PWM channel: phase lengths, tick counter, pin level and held brightness.
module dpwm_channel #(
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dpwm_pkg::dpwm_ctrl_t          ctrl,
	input  logic [SAMPLE_BITS-1:0]        sample,
	input  logic [dpwm_pkg::PERIOD_W-1:0] period,
	output logic                          level_nxt
);

	localparam int unsigned CW = dpwm_pkg::PERIOD_W;

	logic [CW-1:0]          count_q;
	logic [CW-1:0]          high_q;
	logic [CW-1:0]          low_q;
	logic                   level_q;
	logic [SAMPLE_BITS-1:0] held_q;

	logic [SAMPLE_BITS-1:0] duty;
	logic [CW-1:0]          on_ticks;
	logic [CW-1:0]          limit;
	logic                   wrap;

	// Off channels get zero duty; dimming channels follow the sample; other on channels use the held brightness.
	always_comb begin
		if (!ctrl.on_mode) begin
			duty = '0;
		end else if (ctrl.dim_mode) begin
			duty = sample;
		end else begin
			duty = held_q;
		end
	end

	dpwm_scale #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_scale (
		.period  (period),
		.duty    (duty),
		.on_ticks(on_ticks)
	);

	// Phase end test; a zero-length next phase keeps the current level.
	always_comb begin
		limit     = level_q ? high_q : low_q;
		wrap      = (count_q >= limit);
		level_nxt = level_q;
		if (ctrl.tick && wrap) begin
			if (level_q) begin
				level_nxt = (low_q != '0) ? 1'b0 : 1'b1;
			end else begin
				level_nxt = (high_q != '0) ? 1'b1 : 1'b0;
			end
		end
	end

	// Counter and pin level advance on ticks; phase lengths change on updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			high_q  <= '0;
			low_q   <= dpwm_pkg::PERIOD_RST;
			level_q <= 1'b0;
			held_q  <= '1;
		end else begin
			if (ctrl.tick) begin
				count_q <= wrap ? CW'(1) : count_q + CW'(1);
				level_q <= level_nxt;
			end
			if (ctrl.update) begin
				high_q <= on_ticks;
				low_q  <= period - on_ticks;
				if (ctrl.on_mode && ctrl.dim_mode) begin
					held_q <= sample;
				end
			end
		end
	end

	// After an update the two phases always add up to the period.
	a_phase_sum: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.update |=> ({1'b0, high_q} + {1'b0, low_q}) == {1'b0, $past(period)})
		else $error("phase lengths do not add up to the period");

	// A tick always leaves a nonzero count.
	a_count_nz: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.tick |=> count_q != '0)
		else $error("tick counter is zero after a tick");

	// The level only changes on a tick that ends a phase.
	a_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.tick && wrap) |=> $stable(level_q))
		else $error("pin level changed without a phase end");

	// An update item never moves the counter.
	a_update_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.update && !ctrl.tick) |=> $stable(count_q))
		else $error("counter moved on an update item");

endmodule

// File: src/two_channel_dimmer_pwm.sv
// Top level of the two-channel dimmer PWM: input stage, channels, result register.
//
// Each input item is either a tick, which advances both channel counters, or a
// duty update, which recomputes both channels' on and off times from the sample
// and the mode flags. The block takes one item per clock cycle unless out_ready
// stalls the result register; every item returns exactly one result with both
// pin levels after that item, through the input register, then the result
// register. The duty scaling multiply and its constant division sit between
// those two registers. The period register is written through its own channel,
// which is always ready, and should only be written while no item is in flight.
module two_channel_dimmer_pwm #(
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dpwm_pkg::PERIOD_W-1:0] period_ticks,
	// input items
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic [SAMPLE_BITS-1:0]        pot_sample,
	input  logic                          on_mode_a,
	input  logic                          dim_mode_a,
	input  logic                          on_mode_b,
	input  logic                          dim_mode_b,
	// results
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          level_a,
	output logic                          level_b
);

	logic [dpwm_pkg::PERIOD_W-1:0] period_q;

	logic                   valid_s1;
	dpwm_pkg::dpwm_op_t     op_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   on_a_s1;
	logic                   dim_a_s1;
	logic                   on_b_s1;
	logic                   dim_b_s1;

	logic out_valid_q;
	logic level_a_q;
	logic level_b_q;

	logic                 advance;
	logic                 is_tick;
	logic                 is_update;
	dpwm_pkg::dpwm_ctrl_t ctrl_a;
	dpwm_pkg::dpwm_ctrl_t ctrl_b;
	logic                 level_a_nxt;
	logic                 level_b_nxt;

	// Period register; every transfer on the configuration channel writes it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= dpwm_pkg::PERIOD_RST;
		end else if (cfg_valid) begin
			period_q <= period_ticks;
		end
	end

	// The staged item moves on whenever the result register is free or draining.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1     <= dpwm_pkg::dpwm_op_t'(opcode);
			sample_s1 <= pot_sample;
			on_a_s1   <= on_mode_a;
			dim_a_s1  <= dim_mode_a;
			on_b_s1   <= on_mode_b;
			dim_b_s1  <= dim_mode_b;
		end
	end

	// Decode the staged item into per-channel control.
	assign is_tick   = advance && (op_s1 == dpwm_pkg::OP_TICK);
	assign is_update = advance && (op_s1 == dpwm_pkg::OP_UPDATE);

	always_comb begin
		ctrl_a.tick     = is_tick;
		ctrl_a.update   = is_update;
		ctrl_a.on_mode  = on_a_s1;
		ctrl_a.dim_mode = dim_a_s1;
		ctrl_b.tick     = is_tick;
		ctrl_b.update   = is_update;
		ctrl_b.on_mode  = on_b_s1;
		ctrl_b.dim_mode = dim_b_s1;
	end

	dpwm_channel #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_chan_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl_a),
		.sample   (sample_s1),
		.period   (period_q),
		.level_nxt(level_a_nxt)
	);

	dpwm_channel #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_chan_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl_b),
		.sample   (sample_s1),
		.period   (period_q),
		.level_nxt(level_b_nxt)
	);

	// Result register; holds until the result transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			level_a_q <= level_a_nxt;
			level_b_q <= level_b_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign level_a   = level_a_q;
	assign level_b   = level_b_q;

	// A staged item that cannot move on stays staged.
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("staged item lost while the result register was full");

	// Every item that leaves the input stage produces a pending result.
	a_result_made: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed item did not produce a result");

	// Tick and update control are never raised together.
	a_ctrl_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(is_tick && is_update))
		else $error("tick and update decoded at once");

endmodule
